// ===== sv/smsm_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants for the segment mean block
// no dependencies

package smsm_pkg;

    localparam int MaxSegment  = 4096;
    localparam int MaxSegments = 64;

    localparam int SampleW = 32;
    localparam int SumW    = 44;
    localparam int LenW    = 13;
    localparam int CntW    = 7;
    localparam int IdxW    = 6;
    localparam int CfgIdxW = 8;
    localparam int CfgDatW = 16;
    localparam int OutDatW = 56;

    localparam int QueueDepth = 4;
    localparam int QPtrW      = 2;
    localparam int QCntW      = 3;

    localparam int DivStepW = 6;

    localparam logic [LenW-1:0] ResetLength = LenW'(730);
    localparam logic [CntW-1:0] ResetCount  = CntW'(12);

    localparam logic [LenW-1:0] LenMax = LenW'(MaxSegment);
    localparam logic [CntW-1:0] CntMax = CntW'(MaxSegments);

    // -777.0 and -999.0 with 8 fraction bits
    localparam logic signed [SampleW-1:0] MissingA = -32'sd198912;
    localparam logic signed [SampleW-1:0] MissingB = -32'sd255744;

    localparam logic [CfgIdxW-1:0] RegSegmentLength = CfgIdxW'(0);
    localparam logic [CfgIdxW-1:0] RegSegmentCount  = CfgIdxW'(1);

    typedef struct packed {
        logic signed [SumW-1:0] sum;
        logic [LenW-1:0]        tally;
        logic [IdxW-1:0]        index;
        logic                   done;
    } seg_entry_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_HOLD
    } back_state_t;

endpackage

// ===== sv/smsm_front.sv =====
`timescale 1ns / 1ps
// front end: config registers, sentinel check, per-segment accumulation
// depends on smsm_pkg

module smsm_front
    import smsm_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CfgIdxW-1:0]        cfg_index,
    input  logic [CfgDatW-1:0]        cfg_data,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic signed [SampleW-1:0] sample,
    input  logic                      column_start,
    input  logic                      q_full,
    output logic                      q_push,
    output seg_entry_t                q_entry
);

    logic [LenW-1:0]        len_reg;
    logic [CntW-1:0]        cnt_reg;
    logic signed [SumW-1:0] sum_reg;
    logic [LenW-1:0]        tally_reg;
    logic [LenW-1:0]        pos_reg;
    logic [IdxW-1:0]        seg_reg;

    logic signed [SumW-1:0] sum_base, sum_next;
    logic [LenW-1:0]        tally_base, tally_next;
    logic [LenW-1:0]        pos_base, pos_next;
    logic [IdxW-1:0]        seg_base, seg_next;
    logic                   missing, seg_end, seg_done, accept;
    logic [LenW-1:0]        len_wr;
    logic [CntW-1:0]        cnt_wr;

    assign cfg_ready = 1'b1;
    assign s_tready  = !q_full;
    assign accept    = s_tvalid && s_tready;

    always_comb
    begin
        len_wr = cfg_data[LenW-1:0];
        if (len_wr == '0)
        begin
            len_wr = LenW'(1);
        end
        else if (len_wr > LenMax)
        begin
            len_wr = LenMax;
        end
        cnt_wr = cfg_data[CntW-1:0];
        if (cnt_wr == '0)
        begin
            cnt_wr = CntW'(1);
        end
        else if (cnt_wr > CntMax)
        begin
            cnt_wr = CntMax;
        end
    end

    always_comb
    begin
        sum_base   = column_start ? '0 : sum_reg;
        tally_base = column_start ? '0 : tally_reg;
        pos_base   = column_start ? '0 : pos_reg;
        seg_base   = column_start ? '0 : seg_reg;
        missing    = (sample == MissingA) || (sample == MissingB);
        sum_next   = missing ? sum_base : sum_base + SumW'(sample);
        tally_next = missing ? tally_base : tally_base + LenW'(1);
        pos_next   = pos_base + LenW'(1);
        seg_end    = pos_next >= len_reg;
        seg_done   = ({1'b0, seg_base} + CntW'(1)) >= cnt_reg;
        seg_next   = seg_done ? '0 : seg_base + IdxW'(1);
    end

    assign q_push        = accept && seg_end;
    assign q_entry.sum   = sum_next;
    assign q_entry.tally = tally_next;
    assign q_entry.index = seg_base;
    assign q_entry.done  = seg_done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= ResetLength;
            cnt_reg <= ResetCount;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                RegSegmentLength: len_reg <= len_wr;
                RegSegmentCount:  cnt_reg <= cnt_wr;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            tally_reg <= '0;
            pos_reg   <= '0;
            seg_reg   <= '0;
        end
        else if (accept)
        begin
            if (seg_end)
            begin
                sum_reg   <= '0;
                tally_reg <= '0;
                pos_reg   <= '0;
                seg_reg   <= seg_next;
            end
            else
            begin
                sum_reg   <= sum_next;
                tally_reg <= tally_next;
                pos_reg   <= pos_next;
                seg_reg   <= seg_base;
            end
        end
    end

endmodule

// ===== sv/smsm_queue.sv =====
`timescale 1ns / 1ps
// short queue of finished segment totals between front and back
// depends on smsm_pkg

module smsm_queue
    import smsm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  seg_entry_t push_entry,
    input  logic       pop,
    output seg_entry_t pop_entry,
    output logic       full,
    output logic       empty
);

    seg_entry_t       mem_reg [QueueDepth];
    logic [QPtrW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCntW-1:0] count_reg;
    logic             do_push, do_pop;

    assign full      = count_reg == QCntW'(QueueDepth);
    assign empty     = count_reg == '0;
    assign do_push   = push && !full;
    assign do_pop    = pop && !empty;
    assign pop_entry = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPtrW'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPtrW'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + QCntW'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - QCntW'(1);
            end
        end
    end

endmodule

// ===== sv/smsm_back.sv =====
`timescale 1ns / 1ps
// back end: bit-serial signed divide of segment sum by valid count, output register
// depends on smsm_pkg

module smsm_back
    import smsm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_empty,
    input  seg_entry_t        q_entry,
    output logic              q_pop,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [OutDatW-1:0] m_tdata,
    output logic              m_tlast
);

    back_state_t state_reg, state_next;

    logic [SumW-1:0]     mag_reg;
    logic [LenW-1:0]     rem_reg;
    logic [LenW-1:0]     div_reg;
    logic                neg_reg;
    logic [DivStepW-1:0] step_reg;
    logic [IdxW-1:0]     idx_reg;
    logic                done_reg;

    logic                out_valid_reg;
    logic [SampleW-1:0]  out_avg_reg;
    logic [IdxW-1:0]     out_idx_reg;
    logic [LenW-1:0]     out_cnt_reg;
    logic                out_done_reg;

    logic                load, step, emit, out_free, last_step;
    logic [LenW:0]       rem_shift;
    logic                ge;
    logic [LenW-1:0]     rem_next;
    logic [SampleW-1:0]  quot, avg;
    logic [SumW-1:0]     mag_in;

    assign out_free  = !out_valid_reg || m_tready;
    assign last_step = step_reg == DivStepW'(SumW - 1);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE: if (!q_empty) state_next = BK_DIV;
            BK_DIV:  if (last_step) state_next = BK_HOLD;
            BK_HOLD: if (out_free) state_next = BK_IDLE;
            default: state_next = BK_IDLE;
        endcase
    end

    always_comb
    begin
        load = 1'b0;
        step = 1'b0;
        emit = 1'b0;
        unique case (state_reg)
            BK_IDLE: load = !q_empty;
            BK_DIV:  step = 1'b1;
            BK_HOLD: emit = out_free;
            default: ;
        endcase
    end

    assign q_pop = load;

    always_comb
    begin
        rem_shift = {rem_reg, mag_reg[SumW-1]};
        ge        = rem_shift >= {1'b0, div_reg};
        rem_next  = ge ? LenW'(rem_shift - {1'b0, div_reg}) : rem_shift[LenW-1:0];
        mag_in    = q_entry.sum[SumW-1] ? SumW'(-q_entry.sum) : SumW'(q_entry.sum);
        quot      = mag_reg[SampleW-1:0];
        if (div_reg == '0)
        begin
            avg = '0;
        end
        else
        begin
            avg = neg_reg ? SampleW'(-quot) : quot;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
        end
        else if (load)
        begin
            step_reg <= '0;
        end
        else if (step)
        begin
            step_reg <= step_reg + DivStepW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            mag_reg  <= mag_in;
            rem_reg  <= '0;
            div_reg  <= q_entry.tally;
            neg_reg  <= q_entry.sum[SumW-1];
            idx_reg  <= q_entry.index;
            done_reg <= q_entry.done;
        end
        else if (step)
        begin
            mag_reg <= {mag_reg[SumW-2:0], ge};
            rem_reg <= rem_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_avg_reg  <= avg;
            out_idx_reg  <= idx_reg;
            out_cnt_reg  <= div_reg;
            out_done_reg <= done_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_done_reg;
    assign m_tdata  = {{(OutDatW - SampleW - IdxW - LenW){1'b0}},
                       out_cnt_reg, out_idx_reg, out_avg_reg};

endmodule

// ===== sv/segment_mean_skip_missing.sv =====
`timescale 1ns / 1ps
// segment_mean_skip_missing: mean of non-sentinel samples over fixed-length segments
// top level; depends on smsm_pkg, smsm_front, smsm_queue, smsm_back
//
// usage
//   s_* stream: one sample word a cycle while s_tready is high, s_tdata = sample, s_tuser = column_start
//   m_* stream: one word at each segment end; m_tdata = average, segment_index,
//   valid_count from bit 0 up; m_tlast = column_done
//   cfg_*: register writes (0 segment_length, 1 segment_count), always ready;
//   write only while the block is idle
// timing
//   samples are summed at one per cycle while s_tready is high; each finished
//   segment goes to a four-entry queue and is divided by a one-bit-per-cycle
//   unit (44 steps); m_tvalid rises once the segment's total has passed the
//   queue, the divider and the output register
//   short segments are limited by the divider, which takes one segment at a time
// reset clears all counters and restores segment_length 730, segment_count 12
// a stalled m_tready holds the output word; the queue fills, then s_tready drops

module segment_mean_skip_missing
    import smsm_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CfgIdxW-1:0]        cfg_index,
    input  logic [CfgDatW-1:0]        cfg_data,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [SampleW-1:0]        s_tdata,   // sample
    input  logic                      s_tuser,   // column_start
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [OutDatW-1:0]        m_tdata,   // average, segment_index, valid_count
    output logic                      m_tlast
);

    seg_entry_t push_entry, pop_entry;
    logic       q_push, q_pop, q_full, q_empty;

    smsm_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .sample       (s_tdata),
        .column_start (s_tuser),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_entry      (push_entry)
    );

    smsm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (push_entry),
        .pop        (q_pop),
        .pop_entry  (pop_entry),
        .full       (q_full),
        .empty      (q_empty)
    );

    smsm_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_entry  (pop_entry),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
